// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, constants and helpers shared by the circular deque files.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;
  localparam int CAP_W    = 5;
  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_REAR,
    CELL_PUSH_FRONT,
    CELL_POP_FRONT,
    CELL_POP_REAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [31:0] w;
    w = {{(32-CAP_W){1'b0}}, v};
    if (w == 32'd0) begin
      return CNT_W'(1);
    end else if (w > 32'(DEPTH)) begin
      return CNT_W'(DEPTH);
    end
    return CNT_W'(w);
  endfunction

endpackage

// ===== hdl/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_cmd_if / cdq_rsp_if
// Valid/ready channels for deque commands and results.
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink   (input valid, command, push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic [4:0]         occupancy;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, pop_value, status, occupancy, is_full, is_empty,
                  input ready);
  modport sink   (input valid, pop_value, status, occupancy, is_full, is_empty,
                  output ready);
endinterface

// ===== hdl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One deque slot: holds a word and an occupied bit, shifts with neighbors.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cdq_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [cdq_pkg::DATA_W-1:0]    left_data_i,
  input  logic                                 left_valid_i,
  input  logic signed [cdq_pkg::DATA_W-1:0]    right_data_i,
  input  logic                                 right_valid_i,
  output logic signed [cdq_pkg::DATA_W-1:0]    data_o,
  output logic                                 valid_o,
  output logic                                 tail_o
);
  import cdq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (ctl_i.op)
      CELL_HOLD: ;
      CELL_PUSH_REAR: begin
        if (!valid_q && left_valid_i) begin
          data_d  = ctl_i.value;
          valid_d = 1'b1;
        end
      end
      CELL_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      CELL_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CELL_POP_REAR: begin
        if (valid_q && !right_valid_i) valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tail_o  = valid_q && !right_valid_i;

endmodule

// ===== hdl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue built as a row of shifting cells, front at cell 0.
// ----------------------------------------------------------------------------
// Result: a result word is registered and presented in the cycle after its command is taken.
// Throughput: one command per cycle while the result port is ready; every cell updates in the same edge.
// The output register frees as its word is taken, so no bubble under ready.
// Reset: occupancy zero, all cells empty, capacity 16; no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cdq_cmd_if.sink                        cmd_i,
  cdq_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdq_pkg::ADDR_W-1:0]     paddr,
  input  logic [cdq_pkg::PDATA_W-1:0]    pwdata,
  output logic [cdq_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import cdq_pkg::*;

  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         cap_q;
  logic                     rsp_valid_q;
  logic signed [DATA_W-1:0] pop_q, pop_d;
  status_e                  status_q, status_d;
  logic [CNT_W-1:0]         occ_q;
  logic                     full_q, empty_q;

  cell_ctl_t                ctl;
  logic                     accept;
  logic                     cfg_wr;
  logic                     is_full, is_empty;
  cmd_e                     cmd;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_tail;
  logic signed [DATA_W-1:0] tail_data;

  assign cmd       = cmd_e'(cmd_i.command);
  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign is_full   = count_q >= cap_q;
  assign is_empty  = count_q == '0;

  // command decode
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = cmd_i.push_value;
    count_d   = count_q;
    status_d  = ST_DONE;
    pop_d     = '0;
    unique case (cmd)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op  = (cmd == CMD_PUSH_REAR) ? CELL_PUSH_REAR : CELL_PUSH_FRONT;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.op  = (cmd == CMD_POP_FRONT) ? CELL_POP_FRONT : CELL_POP_REAR;
          pop_d   = (cmd == CMD_POP_FRONT) ? cell_data[0] : tail_data;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (!accept) begin
      ctl.op = CELL_HOLD;
    end
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cell_data[i] & {DATA_W{cell_tail[i]}});
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] ld, rd;
    logic                     lv, rv;
    if (g == 0) begin : g_first
      assign ld = cmd_i.push_value;
      assign lv = 1'b1;
    end else begin : g_mid
      assign ld = cell_data[g-1];
      assign lv = cell_valid[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rd = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rd = cell_data[g+1];
      assign rv = cell_valid[g+1];
    end
    cdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_data_i   (ld),
      .left_valid_i  (lv),
      .right_data_i  (rd),
      .right_valid_i (rv),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .tail_o        (cell_tail[g])
    );
  end

  // config port
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[ADDR_W-1];
  assign pready = 1'b1;
  assign prdata = paddr[ADDR_W-1] ? '0 : PDATA_W'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= clamp_cap(CAP_RESET);
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_wr && is_empty) begin
        cap_q <= clamp_cap(pwdata[CAP_W-1:0]);
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      occ_q    <= count_d;
      full_q   <= count_d == cap_q;
      empty_q  <= count_d == '0;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.pop_value = pop_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = OCC_W'(occ_q);
  assign rsp_o.is_full   = full_q;
  assign rsp_o.is_empty  = empty_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q) else $error("occupancy above capacity");

  a_cells_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q)) else $error("cell row out of step with count");

  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d != ST_DONE |=> $stable(count_q) && $stable(cell_valid))
    else $error("rejected command changed state");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cmd_i.command[1] && !is_full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow deque");

endmodule

// ===== dv/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// Watches the command, result and register ports of the circular deque,
// keeps a shadow ring of the held words, and compares every result word
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module deque_checker #(
  parameter logic [cdq_pkg::ADDR_W-1:0] CAP_ADDR = '0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cdq_cmd_if                          cmd_i,
  cdq_rsp_if                          rsp_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [cdq_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [cdq_pkg::PDATA_W-1:0] pwdata_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          checked_o
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_e           status;
    logic [OCC_W-1:0]  occupancy;
    logic              is_full;
    logic              is_empty;
  } deque_result_t;

  deque_result_t     awaited_results[$];
  logic [DATA_W-1:0] held_words[DEPTH];
  logic [IDX_W-1:0]  front_idx;
  logic [IDX_W-1:0]  rear_idx;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  capacity;

  function automatic logic [CNT_W-1:0] legal_capacity(input logic [CAP_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > DEPTH) return CNT_W'(DEPTH);
    return CNT_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= capacity) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
    if (i == '0 || CNT_W'(i) >= capacity) return IDX_W'(capacity - CNT_W'(1));
    return i - IDX_W'(1);
  endfunction

  function automatic deque_result_t apply_command(input cmd_e op,
                                                  input logic [DATA_W-1:0] value);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = ST_DONE;
    case (op)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (held >= capacity) begin
          r.status = ST_FULL;
        end else if (op == CMD_PUSH_REAR) begin
          held_words[rear_idx] = value;
          rear_idx = wrap_up(rear_idx);
          held++;
        end else begin
          front_idx = wrap_down(front_idx);
          held_words[front_idx] = value;
          held++;
        end
      end
      default: begin
        if (held == '0) begin
          r.status = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          r.pop_value = held_words[front_idx];
          front_idx = wrap_up(front_idx);
          held--;
        end else begin
          rear_idx = wrap_down(rear_idx);
          r.pop_value = held_words[rear_idx];
          held--;
        end
      end
    endcase
    r.occupancy = OCC_W'(held);
    r.is_full   = (held == capacity);
    r.is_empty  = (held == '0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      front_idx    = '0;
      rear_idx     = '0;
      held         = '0;
      capacity     = legal_capacity(CAP_RESET);
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // capacity only lands on an empty deque; pointers restart at zero
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CAP_ADDR &&
          held == '0) begin
        capacity  = legal_capacity(pwdata_i[CAP_W-1:0]);
        front_idx = '0;
        rear_idx  = '0;
      end
      if (cmd_i.valid && cmd_i.ready) begin
        awaited_results.push_back(apply_command(cmd_e'(cmd_i.command), cmd_i.push_value));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no command waiting");
          mismatches_o++;
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (rsp_i.pop_value !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, rsp_i.pop_value);
            mismatches_o++;
          end
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatches_o++;
          end
          if (rsp_i.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_i.occupancy);
            mismatches_o++;
          end
          if (rsp_i.is_full !== want.is_full) begin
            $error("is_full: expected %b, got %b", want.is_full, rsp_i.is_full);
            mismatches_o++;
          end
          if (rsp_i.is_empty !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, rsp_i.is_empty);
            mismatches_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the circular deque with a short directed run over empty, full and
// capacity corner cases, then phases of random commands at varied
// capacities, with bursty input, a stalling output and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cdq_pkg::*;

  localparam logic [ADDR_W-1:0] CAP_ADDR    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);
  localparam int HOLD_CYCLES = 120;
  localparam int PHASES      = 12;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_TOGGLE, STALL_HEAVY} stall_e;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               hold_req;
  int                 mismatches;
  int                 pending;
  int                 checked;
  int                 words_sent;
  int                 reg_writes;
  int                 burst_left;

  cdq_cmd_if cmd_if();
  cdq_rsp_if rsp_if();

  circular_deque dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  deque_checker #(.CAP_ADDR(CAP_ADDR)) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .rsp_i        (rsp_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input cmd_e op, input logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd_if.valid      = 1'b1;
    cmd_if.command    = op;
    cmd_if.push_value = value;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic settle();
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    reg_writes++;
  endtask

  task automatic set_capacity(input logic [PDATA_W-1:0] data);
    settle();
    write_register(CAP_ADDR, data);
  endtask

  initial begin
    stall_e mode;
    int     span;
    rsp_if.ready = 1'b0;
    forever begin
      mode = stall_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req) begin
          rsp_if.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            STALL_NONE:   rsp_if.ready = 1'b1;
            STALL_COIN:   rsp_if.ready = 1'($urandom_range(0, 1));
            STALL_TOGGLE: rsp_if.ready = ~rsp_if.ready;
            default:      rsp_if.ready = ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int                push_pct;
    int                count;
    logic [PDATA_W-1:0] cap_word;
    logic [DATA_W-1:0]  value;
    cmd_e              op;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_PUSH_REAR;
    cmd_if.push_value = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    burst_left        = 0;
    words_sent        = 0;
    reg_writes        = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(CMD_POP_FRONT,  32'h0000_0000);
    send_word(CMD_POP_REAR,   32'h1234_5678);
    send_word(CMD_PUSH_REAR,  32'h7FFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(CMD_PUSH_REAR,  32'h0000_0000);
    send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(CMD_POP_FRONT,  32'hFFFF_FFFF);
    send_word(CMD_POP_REAR,   32'h0000_0000);
    send_word(CMD_POP_REAR,   32'h5555_5555);
    send_word(CMD_POP_FRONT,  32'hAAAA_AAAA);

    // zero capacity acts as one
    set_capacity(32'd0);
    send_word(CMD_PUSH_FRONT, 32'hA5A5_5A5A);
    send_word(CMD_PUSH_REAR,  32'h5A5A_A5A5);
    send_word(CMD_POP_FRONT,  32'h0000_0000);
    send_word(CMD_POP_REAR,   32'h0000_0000);

    set_capacity(32'd2);
    send_word(CMD_PUSH_REAR,  32'h0000_0001);
    send_word(CMD_PUSH_FRONT, 32'h0000_0002);
    send_word(CMD_PUSH_REAR,  32'h0000_0003);

    // neither write may take effect: wrong register, deque not empty
    settle();
    write_register(UNUSED_ADDR, 32'd7);
    set_capacity(32'd9);
    send_word(CMD_PUSH_FRONT, 32'h0000_0004);
    send_word(CMD_POP_REAR,   32'h0000_0000);
    send_word(CMD_POP_REAR,   32'h0000_0000);
    send_word(CMD_POP_FRONT,  32'h0000_0000);

    // upper data bits ignored
    set_capacity(32'hFFFF_FFE3);
    send_word(CMD_PUSH_REAR,  32'hDEAD_0001);
    send_word(CMD_PUSH_FRONT, 32'hDEAD_0002);
    send_word(CMD_PUSH_REAR,  32'hDEAD_0003);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       cap_word = 32'd16;
        1:       cap_word = 32'd1;
        2:       cap_word = 32'd31;
        3:       cap_word = 32'd0;
        4:       cap_word = 32'd2;
        default: cap_word = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 31);
      endcase
      if (p % 4 == 3) begin
        settle();
        write_register(UNUSED_ADDR, $urandom());
      end
      set_capacity(cap_word);
      if (p == 2) hold_req = 1'b1;
      push_pct = (p == 2) ? 90 : $urandom_range(15, 85);
      count    = $urandom_range(90, 115);
      repeat (count) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = ($urandom_range(0, 1) == 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else begin
          op = ($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_REAR;
        end
        case ($urandom_range(0, 15))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom();
        endcase
        send_word(op, value);
      end
      // drain in the early phases and most later ones, so the next capacity write lands
      if (p < 6 || $urandom_range(0, 3) != 0) begin
        repeat (DEPTH) begin
          send_word(($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom());
        end
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    $display("Run: %0d command words, %0d result words compared, %0d register writes.",
             words_sent, checked, reg_writes);
    $display("Capacities from one to full depth, bursty input, stalled output, one long hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cdq_pkg.sv
hdl/cdq_if.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
dv/deque_checker.sv
dv/testbench.sv
